// ===== rtl/lsf_pkg.sv =====
package lsf_pkg;

  // Sieve range and prime list size
  localparam int MAX_NUMBER  = 1048576;
  localparam int PRIME_SLOTS = 131072;
  localparam int NUM_W       = $clog2(MAX_NUMBER);
  localparam int PIDX_W      = $clog2(PRIME_SLOTS);
  localparam int PCNT_W      = PIDX_W + 1;
  localparam int STEP_W      = $clog2(NUM_W);

  // Shape codes
  localparam logic [1:0] SHAPE_NONE  = 2'd0;
  localparam logic [1:0] SHAPE_POWER = 2'd1;
  localparam logic [1:0] SHAPE_TWO   = 2'd2;

  // Command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_PAST    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [NUM_W-1:0]  number;
  } cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [NUM_W-1:0] least_factor;
    logic [1:0]       shape_kind;
    logic [NUM_W-1:0] first_prime;
    logic [NUM_W-1:0] second_prime;
    logic             is_last;
    logic             past_end;
  } result_t;

endpackage

// ===== rtl/lsf_div.sv =====
module lsf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lsf_pkg::NUM_W-1:0] dividend,
  input  logic [lsf_pkg::NUM_W-1:0] divisor,
  output logic                      done,
  output logic [lsf_pkg::NUM_W-1:0] quot,
  output logic [lsf_pkg::NUM_W-1:0] rem
);
  import lsf_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  dvs;
  logic [NUM_W:0]    r_sh;
  logic [NUM_W:0]    diff;

  // one quotient bit per cycle, restoring
  assign r_sh = {rem, quot[NUM_W-1]};
  assign diff = r_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[NUM_W]) begin
          rem  <= diff[NUM_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= r_sh[NUM_W-1:0];
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lsf_front.sv =====
module lsf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      restart,
  output logic                      full,
  input  logic [lsf_pkg::NUM_W-1:0] lim,
  input  logic                      init_busy,
  output logic                      cmd_valid,
  output lsf_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import lsf_pkg::*;

  logic [NUM_W-1:0] cur;
  logic             finished;
  cmd_t             q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             accept;
  cmd_t             new_cmd;

  assign full      = (count == 2'd2) || init_busy;
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_mem[rd_ptr];

  // classify the incoming item
  always_comb begin
    if (restart) begin
      new_cmd.kind   = CMD_RESTART;
      new_cmd.number = NUM_W'(2);
    end else if (finished || cur >= lim) begin
      new_cmd.kind   = CMD_PAST;
      new_cmd.number = cur;
    end else begin
      new_cmd.kind   = CMD_ADVANCE;
      new_cmd.number = cur + NUM_W'(1);
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= NUM_W'(1);
      finished <= 1'b0;
    end else if (accept) begin
      unique case (new_cmd.kind)
        CMD_RESTART: begin
          cur      <= NUM_W'(2);
          finished <= 1'b0;
        end
        CMD_PAST: finished <= 1'b1;
        CMD_ADVANCE: cur <= new_cmd.number;
        default: ;
      endcase
    end
  end

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (accept) q_mem[wr_ptr] <= new_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, cmd_pop};
    end
  end

endmodule

// ===== rtl/lsf_outq.sv =====
module lsf_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  lsf_pkg::result_t din,
  output logic             qfull,
  input  logic             rd,
  output lsf_pkg::result_t dout,
  output logic             qempty
);
  import lsf_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_rd;

  assign qfull  = (count == 2'd2);
  assign qempty = (count == 2'd0);
  assign dout   = mem[rd_ptr];
  assign do_rd  = rd && !qempty;

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/lsf_back.sv =====
module lsf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lsf_pkg::NUM_W-1:0] lim,
  input  logic                      cmd_valid,
  input  lsf_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic                      out_full,
  output logic                      out_push,
  output lsf_pkg::result_t          out_data,
  output logic                      init_busy
);
  import lsf_pkg::*;

  typedef enum logic [14:0] {
    S_INIT   = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_CLEAR  = 15'b000000000000100,
    S_RD_N   = 15'b000000000001000,
    S_CHK_N  = 15'b000000000010000,
    S_PL_RD  = 15'b000000000100000,
    S_PL_MUL = 15'b000000001000000,
    S_PL_CMP = 15'b000000010000000,
    S_PL_DIV = 15'b000000100000000,
    S_CLS0   = 15'b000001000000000,
    S_CLS1   = 15'b000010000000000,
    S_STRIP1 = 15'b000100000000000,
    S_CLS2   = 15'b001000000000000,
    S_STRIP2 = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  state_t             state;
  logic [NUM_W-1:0]   n;
  logic [NUM_W-1:0]   m;
  logic [NUM_W-1:0]   p;
  logic [NUM_W-1:0]   q;
  logic [NUM_W-1:0]   lf;
  logic [NUM_W-1:0]   pp;
  logic [2*NUM_W-1:0] prod;
  logic [PCNT_W-1:0]  j;
  logic [PCNT_W-1:0]  pcount;
  logic [NUM_W-1:0]   hwm;
  logic [NUM_W-1:0]   clr_addr;
  logic [1:0]         kind;
  logic [NUM_W-1:0]   fp;
  logic [NUM_W-1:0]   sp;
  result_t            last_res;

  // factor table and prime list
  logic [NUM_W-1:0]   ft_mem [MAX_NUMBER];
  logic [NUM_W-1:0]   pl_mem [PRIME_SLOTS];
  logic               ft_we;
  logic [NUM_W-1:0]   ft_waddr;
  logic [NUM_W-1:0]   ft_wdata;
  logic [NUM_W-1:0]   ft_raddr;
  logic [NUM_W-1:0]   ft_rdata;
  logic               pl_we;
  logic [PIDX_W-1:0]  pl_waddr;
  logic [PIDX_W-1:0]  pl_raddr;
  logic [NUM_W-1:0]   pl_rdata;

  // divider
  logic               div_start;
  logic [NUM_W-1:0]   div_a;
  logic [NUM_W-1:0]   div_b;
  logic               div_done;
  logic [NUM_W-1:0]   div_q;
  logic [NUM_W-1:0]   div_r;

  logic               mark_ok;
  logic               list_room;

  lsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign init_busy = (state == S_INIT);
  assign mark_ok   = (pp != '0) && (prod <= {{NUM_W{1'b0}}, lim});
  assign list_room = (pcount != PCNT_W'(PRIME_SLOTS));

  always_ff @(posedge clk) begin
    if (ft_we) ft_mem[ft_waddr] <= ft_wdata;
    ft_rdata <= ft_mem[ft_raddr];
  end

  always_ff @(posedge clk) begin
    if (pl_we) pl_mem[pl_waddr] <= n;
    pl_rdata <= pl_mem[pl_raddr];
  end

  // memory ports, divider launch and handshakes
  always_comb begin
    ft_we     = 1'b0;
    ft_waddr  = n;
    ft_wdata  = n;
    ft_raddr  = n;
    pl_we     = 1'b0;
    pl_waddr  = pcount[PIDX_W-1:0];
    pl_raddr  = j[PIDX_W-1:0];
    div_start = 1'b0;
    div_a     = m;
    div_b     = p;
    cmd_pop   = 1'b0;
    out_push  = 1'b0;
    out_data  = '{number: n, least_factor: lf, shape_kind: kind, first_prime: fp,
                  second_prime: sp, is_last: (n == lim), past_end: 1'b0};
    unique case (state)
      S_INIT, S_CLEAR: begin
        ft_we    = 1'b1;
        ft_waddr = clr_addr;
        ft_wdata = '0;
      end
      S_IDLE: begin
        if (cmd_valid && !out_full) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_PAST) begin
            out_push          = 1'b1;
            out_data          = last_res;
            out_data.past_end = 1'b1;
          end
        end
      end
      S_CHK_N: begin
        if (ft_rdata == '0) begin
          ft_we = 1'b1;
          pl_we = list_room;
        end
      end
      S_PL_CMP: begin
        if (mark_ok) begin
          ft_we     = 1'b1;
          ft_waddr  = prod[NUM_W-1:0];
          ft_wdata  = pp;
          div_start = 1'b1;
          div_a     = n;
          div_b     = pp;
        end
      end
      S_CLS1: begin
        div_b     = ft_rdata;
        div_start = (ft_rdata >= NUM_W'(2));
      end
      S_STRIP1: begin
        ft_raddr = m;
        if (div_done && div_r == '0) begin
          div_start = 1'b1;
          div_a     = div_q;
        end
      end
      S_CLS2: begin
        div_b     = ft_rdata;
        div_start = (ft_rdata >= NUM_W'(2));
      end
      S_STRIP2: begin
        div_b = q;
        if (div_done && div_r == '0) begin
          div_start = 1'b1;
          div_a     = div_q;
        end
      end
      S_OUT: out_push = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      hwm      <= NUM_W'(MAX_NUMBER - 1);
      pcount   <= '0;
      last_res <= '0;
    end else begin
      // track highest written entry so a restart clears only that far
      if (ft_we && state != S_INIT && state != S_CLEAR && ft_waddr > hwm) hwm <= ft_waddr;
      unique case (state)
        S_INIT, S_CLEAR: begin
          clr_addr <= clr_addr + NUM_W'(1);
          if (clr_addr == hwm) begin
            hwm   <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_RD_N;
          end
        end
        S_IDLE: begin
          if (cmd_valid && !out_full) begin
            unique case (cmd.kind)
              CMD_RESTART: begin
                n        <= NUM_W'(2);
                pcount   <= '0;
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              CMD_ADVANCE: begin
                n     <= cmd.number;
                state <= S_RD_N;
              end
              CMD_PAST: last_res.past_end <= 1'b1;
              default: ;
            endcase
          end
        end
        S_RD_N: state <= S_CHK_N;
        S_CHK_N: begin
          if (ft_rdata == '0 && list_room) pcount <= pcount + PCNT_W'(1);
          j     <= '0;
          state <= S_PL_RD;
        end
        S_PL_RD: state <= (j >= pcount) ? S_CLS0 : S_PL_MUL;
        S_PL_MUL: begin
          pp    <= pl_rdata;
          prod  <= (2*NUM_W)'(n) * (2*NUM_W)'(pl_rdata);
          state <= S_PL_CMP;
        end
        S_PL_CMP: state <= mark_ok ? S_PL_DIV : S_CLS0;
        S_PL_DIV: begin
          if (div_done) begin
            if (div_r == '0) begin
              state <= S_CLS0;
            end else begin
              j     <= j + PCNT_W'(1);
              state <= S_PL_RD;
            end
          end
        end
        S_CLS0: begin
          m     <= n;
          state <= S_CLS1;
        end
        S_CLS1: begin
          p  <= ft_rdata;
          lf <= ft_rdata;
          if (ft_rdata < NUM_W'(2)) begin
            kind  <= SHAPE_NONE;
            fp    <= '0;
            sp    <= '0;
            state <= S_OUT;
          end else begin
            state <= S_STRIP1;
          end
        end
        S_STRIP1: begin
          if (div_done) begin
            if (div_r == '0) begin
              m <= div_q;
            end else if (m == NUM_W'(1)) begin
              kind  <= SHAPE_POWER;
              fp    <= p;
              sp    <= '0;
              state <= S_OUT;
            end else begin
              state <= S_CLS2;
            end
          end
        end
        S_CLS2: begin
          q <= ft_rdata;
          if (ft_rdata < NUM_W'(2)) begin
            kind  <= SHAPE_NONE;
            fp    <= '0;
            sp    <= '0;
            state <= S_OUT;
          end else begin
            state <= S_STRIP2;
          end
        end
        S_STRIP2: begin
          if (div_done) begin
            if (div_r == '0) begin
              m <= div_q;
            end else begin
              if (m == NUM_W'(1) && q != p) begin
                kind <= SHAPE_TWO;
                fp   <= p;
                sp   <= q;
              end else begin
                kind <= SHAPE_NONE;
                fp   <= '0;
                sp   <= '0;
              end
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          last_res <= out_data;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/linear_sieve_factor_shape.sv =====
// Linear sieve stepper with least-factor lookup and factor-shape tagging.
// Input queue side: restart is taken when push is high and full is low.
//   restart=1 starts over at 2, restart=0 moves to the next integer or past_end.
// Result queue side: while empty is low the oldest result is on the
//   result ports; pop takes it. Every item gives exactly one result.
// Config: cfg_we writes cfg_data into the limit register (reset 1048575);
//   write only while the block is idle.
// Work: an advance tries listed primes while marking multiples, then
//   strips prime powers; the bit-serial divider takes most of that time.
//   A restart first zeroes the factor table up to the highest entry
//   written since the last clear, one entry per cycle.
//   An advance past the limit is answered from the idle state.
// Reset: the whole factor table (1048576 entries) is zeroed, one entry a
//   cycle; full stays high for that time.
// Stalls: a two-deep command queue and a two-deep result queue decouple
//   the sides; when the result queue fills the engine waits and full
//   rises once the command queue fills as well.
module linear_sieve_factor_shape (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        restart,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [19:0] number,
  output logic [19:0] least_factor,
  output logic [1:0]  shape_kind,
  output logic [19:0] first_prime,
  output logic [19:0] second_prime,
  output logic        is_last,
  output logic        past_end,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data
);
  import lsf_pkg::*;

  logic [NUM_W-1:0] lim;
  logic             init_busy;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             out_full;
  logic             out_push;
  result_t          out_data;
  result_t          head;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) lim <= '1;
    else if (cfg_we) lim <= cfg_data;
  end

  lsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .restart   (restart),
    .full      (full),
    .lim       (lim),
    .init_busy (init_busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_data),
    .init_busy (init_busy)
  );

  lsf_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (out_push),
    .din    (out_data),
    .qfull  (out_full),
    .rd     (pop),
    .dout   (head),
    .qempty (empty)
  );

  assign number       = head.number;
  assign least_factor = head.least_factor;
  assign shape_kind   = head.shape_kind;
  assign first_prime  = head.first_prime;
  assign second_prime = head.second_prime;
  assign is_last      = head.is_last;
  assign past_end     = head.past_end;

endmodule
